[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master transfer engine.
// Used by the front end, the bus engine and the top-level wrapper.
package i2cm_pkg;

  localparam int unsigned DEF_COUNT_BITS = 8;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_FREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SETUP = 3'd5;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_SUPPLY = 2'd2,
    ACT_NOP    = 2'd3
  } act_e;

  typedef struct packed {
    logic [7:0] clock_low;
    logic [7:0] clock_high;
    logic [7:0] data_setup;
    logic [7:0] bus_free;
    logic [7:0] start_hold;
    logic [7:0] stop_setup;
  } cfg_t;

  typedef struct packed {
    act_e       kind;
    logic [7:0] byte_val;
    logic       sda;
    logic       scl;
  } cmd_t;

  typedef struct packed {
    logic       sda_drive;
    logic       scl_drive;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       need_byte;
    logic       busy;
    logic       done;
    logic       failed;
  } res_t;

endpackage

[rtl/i2cm_front.sv]
// Front end: classifies an incoming transaction into a compact command.
// Depends on i2cm_pkg.
module i2cm_front #(
  parameter int unsigned COUNT_BITS = i2cm_pkg::DEF_COUNT_BITS
) (
  input  logic [1:0]            action_i,
  input  logic [7:0]            addr_byte_i,
  input  logic [7:0]            byte_count_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  sda_in_i,
  input  logic                  scl_in_i,
  output i2cm_pkg::cmd_t        cmd_o,
  output logic [COUNT_BITS-1:0] count_o
);
  import i2cm_pkg::*;

  localparam int unsigned EXT_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  logic [EXT_W-1:0] count_ext;
  act_e             kind;

  assign kind      = act_e'(action_i);
  assign count_ext = EXT_W'(byte_count_i);

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind;
    count_o    = '0;
    unique case (kind)
      ACT_TICK: begin
        cmd_o.sda = sda_in_i;
        cmd_o.scl = scl_in_i;
      end
      ACT_BEGIN: begin
        cmd_o.byte_val = addr_byte_i;
        count_o        = count_ext[COUNT_BITS-1:0];
      end
      ACT_SUPPLY: begin
        cmd_o.byte_val = data_byte_i;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/i2cm_queue.sv]
// Short command queue between the front end and the bus engine.
// Self-contained; no package dependency.
module i2cm_queue #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/i2cm_back.sv]
// Bus engine: runs the I2C phase sequencer one command per cycle while its result register
// is free or being read. Holds the result in an output register. Depends on i2cm_pkg.
module i2cm_back #(
  parameter int unsigned COUNT_BITS = i2cm_pkg::DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cm_pkg::cfg_t        cfg_i,
  input  logic                  cmd_valid_i,
  input  i2cm_pkg::cmd_t        cmd_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output i2cm_pkg::res_t        res_o
);
  import i2cm_pkg::*;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_FREE    = 5'd1;
  localparam logic [4:0] PH_SHOLD   = 5'd2;
  localparam logic [4:0] PH_SLOW    = 5'd3;
  localparam logic [4:0] PH_WSETUP  = 5'd4;
  localparam logic [4:0] PH_WRISE   = 5'd5;
  localparam logic [4:0] PH_WHIGH   = 5'd6;
  localparam logic [4:0] PH_WLOW    = 5'd7;
  localparam logic [4:0] PH_ASETUP  = 5'd8;
  localparam logic [4:0] PH_ARISE   = 5'd9;
  localparam logic [4:0] PH_AHIGH   = 5'd10;
  localparam logic [4:0] PH_ALOW    = 5'd11;
  localparam logic [4:0] PH_NEED    = 5'd12;
  localparam logic [4:0] PH_RRISE   = 5'd13;
  localparam logic [4:0] PH_RHIGH   = 5'd14;
  localparam logic [4:0] PH_RLOW    = 5'd15;
  localparam logic [4:0] PH_STPREP  = 5'd16;
  localparam logic [4:0] PH_STSETUP = 5'd17;

  function automatic logic [7:0] at_least_one(input logic [7:0] t);
    return (t == 8'd0) ? 8'd1 : t;
  endfunction

  logic [4:0]            phase_q, phase_d;
  logic [7:0]            timer_q, timer_d;
  logic [3:0]            bit_q, bit_d;
  logic [7:0]            shift_q, shift_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic                  read_q, read_d;
  logic                  sda_q, sda_d;
  logic                  scl_q, scl_d;
  logic                  astage_q, astage_d;
  logic                  fail_q, fail_d;
  logic                  ev_rx, ev_done, rd_last;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign rd_last     = (left_q == COUNT_BITS'(1));

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    left_d   = left_q;
    read_d   = read_q;
    sda_d    = sda_q;
    scl_d    = scl_q;
    astage_d = astage_q;
    fail_d   = fail_q;
    ev_rx    = 1'b0;
    ev_done  = 1'b0;

    unique case (cmd_i.kind)
      ACT_TICK: begin
        if (phase_q == PH_IDLE || phase_q == PH_NEED) begin
        end else if (phase_q == PH_WRISE || phase_q == PH_ARISE || phase_q == PH_RRISE) begin
          if (cmd_i.scl) begin
            if (phase_q == PH_ARISE) begin
              fail_d = cmd_i.sda;
            end
            phase_d = phase_q + 5'd1;
            scl_d   = 1'b1;
            timer_d = at_least_one(cfg_i.clock_high);
          end
        end else if (timer_q > 8'd1) begin
          timer_d = timer_q - 8'd1;
        end else begin
          unique case (phase_q)
            PH_FREE: begin
              phase_d = PH_SHOLD; sda_d = 1'b0; scl_d = 1'b1;
              timer_d = at_least_one(cfg_i.start_hold);
            end
            PH_SHOLD: begin
              phase_d = PH_SLOW; sda_d = 1'b0; scl_d = 1'b0;
              timer_d = at_least_one(cfg_i.clock_low);
            end
            PH_SLOW: begin
              bit_d   = '0;
              phase_d = PH_WSETUP; sda_d = shift_q[7]; scl_d = 1'b0;
              timer_d = at_least_one(cfg_i.data_setup);
            end
            PH_WSETUP: begin
              phase_d = PH_WRISE; sda_d = shift_q[7]; scl_d = 1'b1; timer_d = 8'd1;
            end
            PH_WHIGH: begin
              phase_d = PH_WLOW; sda_d = shift_q[7]; scl_d = 1'b0;
              timer_d = at_least_one(cfg_i.clock_low);
            end
            PH_WLOW: begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              if (bit_d < 4'd8) begin
                phase_d = PH_WSETUP; sda_d = shift_d[7]; scl_d = 1'b0;
                timer_d = at_least_one(cfg_i.data_setup);
              end else if (read_q && !astage_q) begin
                left_d = left_q - COUNT_BITS'(1);
                if (left_d == '0) begin
                  phase_d = PH_STPREP; sda_d = 1'b0; scl_d = 1'b0;
                  timer_d = at_least_one(cfg_i.data_setup);
                end else begin
                  bit_d = '0; shift_d = '0;
                  phase_d = PH_RRISE; sda_d = 1'b1; scl_d = 1'b1; timer_d = 8'd1;
                end
              end else begin
                phase_d = PH_ASETUP; sda_d = 1'b1; scl_d = 1'b0;
                timer_d = at_least_one(cfg_i.clock_low);
              end
            end
            PH_ASETUP: begin
              phase_d = PH_ARISE; sda_d = 1'b1; scl_d = 1'b1; timer_d = 8'd1;
            end
            PH_AHIGH: begin
              phase_d = PH_ALOW; sda_d = 1'b1; scl_d = 1'b0;
              timer_d = at_least_one(cfg_i.clock_low);
            end
            PH_ALOW: begin
              if (!fail_q) begin
                astage_d = 1'b0;
              end
              if (fail_q || left_q == '0) begin
                phase_d = PH_STPREP; sda_d = 1'b0; scl_d = 1'b0;
                timer_d = at_least_one(cfg_i.data_setup);
              end else if (read_q && astage_q) begin
                bit_d = '0; shift_d = '0;
                phase_d = PH_RRISE; sda_d = 1'b1; scl_d = 1'b1; timer_d = 8'd1;
              end else begin
                phase_d = PH_NEED; sda_d = 1'b1; scl_d = 1'b0; timer_d = 8'd1;
              end
            end
            PH_RHIGH: begin
              shift_d = {shift_q[6:0], cmd_i.sda};
              bit_d   = bit_q + 4'd1;
              ev_rx   = (bit_d >= 4'd8);
              phase_d = PH_RLOW; sda_d = 1'b1; scl_d = 1'b0;
              timer_d = at_least_one(cfg_i.clock_low);
            end
            PH_RLOW: begin
              if (bit_q < 4'd8) begin
                phase_d = PH_RRISE; sda_d = 1'b1; scl_d = 1'b1; timer_d = 8'd1;
              end else begin
                shift_d = {rd_last, 7'd0};
                bit_d   = 4'd7;
                phase_d = PH_WSETUP; sda_d = rd_last; scl_d = 1'b0;
                timer_d = at_least_one(cfg_i.data_setup);
              end
            end
            PH_STPREP: begin
              phase_d = PH_STSETUP; sda_d = 1'b0; scl_d = 1'b1;
              timer_d = at_least_one(cfg_i.stop_setup);
            end
            PH_STSETUP: begin
              phase_d = PH_IDLE; sda_d = 1'b1; scl_d = 1'b1; timer_d = '0;
              ev_done = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE; sda_d = 1'b1; scl_d = 1'b1; timer_d = '0;
            end
          endcase
        end
      end
      ACT_BEGIN: begin
        if (phase_q == PH_IDLE) begin
          shift_d  = cmd_i.byte_val;
          left_d   = count_i;
          read_d   = cmd_i.byte_val[0];
          astage_d = 1'b1;
          fail_d   = 1'b0;
          bit_d    = '0;
          phase_d  = PH_FREE; sda_d = 1'b1; scl_d = 1'b1;
          timer_d  = at_least_one(cfg_i.bus_free);
        end
      end
      ACT_SUPPLY: begin
        if (phase_q == PH_NEED) begin
          shift_d = cmd_i.byte_val;
          left_d  = left_q - COUNT_BITS'(1);
          bit_d   = '0;
          phase_d = PH_WSETUP; sda_d = cmd_i.byte_val[7]; scl_d = 1'b0;
          timer_d = at_least_one(cfg_i.data_setup);
        end
      end
      default: begin
      end
    endcase

    res_d.sda_drive = sda_d;
    res_d.scl_drive = scl_d;
    res_d.rx_byte   = ev_rx ? shift_d : 8'd0;
    res_d.rx_valid  = ev_rx;
    res_d.need_byte = (phase_d == PH_NEED);
    res_d.busy      = (phase_d != PH_IDLE);
    res_d.done      = ev_done;
    res_d.failed    = ev_done && fail_d;

    if (cmd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      left_q      <= '0;
      read_q      <= 1'b0;
      sda_q       <= 1'b1;
      scl_q       <= 1'b1;
      astage_q    <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_pop_o) begin
        phase_q  <= phase_d;
        timer_q  <= timer_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        left_q   <= left_d;
        read_q   <= read_d;
        sda_q    <= sda_d;
        scl_q    <= scl_d;
        astage_q <= astage_d;
        fail_q   <= fail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/i2c_master_transfer.sv]
// An accepted transaction is first written into the queue; the engine then takes it from the queue
// and updates the result register, which holds the result until out_ready_i takes it.
// Throughput: one transaction per cycle while the queue is not full and the result is not stalled.
// Reset (rst_ni low, asynchronous): engine idle, both lines released, queue and result empty,
// timing registers at 5, 4, 1, 5, 4, 4 ticks.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
module i2c_master_transfer #(
  parameter int unsigned COUNT_BITS  = i2cm_pkg::DEF_COUNT_BITS,
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     addr_byte_i,
  input  logic [7:0]                     byte_count_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           sda_in_i,
  input  logic                           scl_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           sda_drive_o,
  output logic                           scl_drive_o,
  output logic [7:0]                     rx_byte_o,
  output logic                           rx_valid_o,
  output logic                           need_byte_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic                           failed_o
);
  import i2cm_pkg::*;

  localparam int unsigned ENTRY_W = $bits(cmd_t) + COUNT_BITS;

  cfg_t                  cfg_q;
  cmd_t                  front_cmd, back_cmd;
  logic [COUNT_BITS-1:0] front_count, back_count;
  logic [ENTRY_W-1:0]    q_in, q_out;
  logic                  q_full, q_valid, q_pop;
  res_t                  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_low  <= 8'd5;
      cfg_q.clock_high <= 8'd4;
      cfg_q.data_setup <= 8'd1;
      cfg_q.bus_free   <= 8'd5;
      cfg_q.start_hold <= 8'd4;
      cfg_q.stop_setup <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CLOCK_LOW:  cfg_q.clock_low  <= cfg_wdata_i;
        REG_CLOCK_HIGH: cfg_q.clock_high <= cfg_wdata_i;
        REG_DATA_SETUP: cfg_q.data_setup <= cfg_wdata_i;
        REG_BUS_FREE:   cfg_q.bus_free   <= cfg_wdata_i;
        REG_START_HOLD: cfg_q.start_hold <= cfg_wdata_i;
        REG_STOP_SETUP: cfg_q.stop_setup <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  i2cm_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .action_i     (action_i),
    .addr_byte_i  (addr_byte_i),
    .byte_count_i (byte_count_i),
    .data_byte_i  (data_byte_i),
    .sda_in_i     (sda_in_i),
    .scl_in_i     (scl_in_i),
    .cmd_o        (front_cmd),
    .count_o      (front_count)
  );

  assign q_in       = {front_cmd, front_count};
  assign in_ready_o = !q_full;

  i2cm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  assign back_cmd   = q_out[ENTRY_W-1:COUNT_BITS];
  assign back_count = q_out[COUNT_BITS-1:0];

  i2cm_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .count_i     (back_count),
    .cmd_pop_o   (q_pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign sda_drive_o = res.sda_drive;
  assign scl_drive_o = res.scl_drive;
  assign rx_byte_o   = res.rx_byte;
  assign rx_valid_o  = res.rx_valid;
  assign need_byte_o = res.need_byte;
  assign busy_res_o  = res.busy;
  assign done_res_o  = res.done;
  assign failed_o    = res.failed;

endmodule

[dv/tb_i2c_master_transfer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_transfer: directed and random I2C transfers
// against an in-bench bus model, with random idling on both handshakes.
// Depends on i2cm_pkg and the i2c_master_transfer RTL.
module tb_i2c_master_transfer;
  import i2cm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 360;

  typedef enum logic [4:0] {
    BP_IDLE, BP_FREE, BP_SHOLD, BP_SLOW,
    BP_WSETUP, BP_WRISE, BP_WHIGH, BP_WLOW,
    BP_ASETUP, BP_ARISE, BP_AHIGH, BP_ALOW,
    BP_NEED, BP_RRISE, BP_RHIGH, BP_RLOW,
    BP_STPREP, BP_STSETUP
  } bus_phase_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            action_i = ACT_NOP;
  logic [7:0]            addr_byte_i = '0;
  logic [7:0]            byte_count_i = '0;
  logic [7:0]            data_byte_i = '0;
  logic                  sda_in_i = 1'b1;
  logic                  scl_in_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  sda_drive_o;
  logic                  scl_drive_o;
  logic [7:0]            rx_byte_o;
  logic                  rx_valid_o;
  logic                  need_byte_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic                  failed_o;

  i2c_master_transfer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .addr_byte_i  (addr_byte_i),
    .byte_count_i (byte_count_i),
    .data_byte_i  (data_byte_i),
    .sda_in_i     (sda_in_i),
    .scl_in_i     (scl_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sda_drive_o  (sda_drive_o),
    .scl_drive_o  (scl_drive_o),
    .rx_byte_o    (rx_byte_o),
    .rx_valid_o   (rx_valid_o),
    .need_byte_o  (need_byte_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .failed_o     (failed_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned bus_items = 0;
  res_t        levels_q[$];

  // bus engine mirror
  cfg_t       timing;
  bus_phase_e ph;
  logic [7:0] ph_timer;
  logic [3:0] bit_idx;
  logic [7:0] shreg;
  logic [7:0] bytes_left;
  logic       rd_mode;
  logic       sda_lvl;
  logic       scl_lvl;
  logic       addr_phase;
  logic       nacked;
  logic       ev_rx;
  logic [7:0] ev_byte;
  logic       ev_done;

  function automatic void enter_ph(bus_phase_e p, logic sda, logic scl, logic [7:0] ticks);
    ph = p;
    sda_lvl = sda;
    scl_lvl = scl;
    ph_timer = (ticks == 8'd0) ? 8'd1 : ticks;
  endfunction

  function automatic void go_stop();
    enter_ph(BP_STPREP, 1'b0, 1'b0, timing.data_setup);
  endfunction

  function automatic void go_read();
    bit_idx = 4'd0;
    shreg = 8'd0;
    enter_ph(BP_RRISE, 1'b1, 1'b1, 8'd1);
  endfunction

  function automatic void phase_expired(logic sda);
    logic b;
    case (ph)
      BP_FREE:   enter_ph(BP_SHOLD, 1'b0, 1'b1, timing.start_hold);
      BP_SHOLD:  enter_ph(BP_SLOW, 1'b0, 1'b0, timing.clock_low);
      BP_SLOW: begin
        bit_idx = 4'd0;
        enter_ph(BP_WSETUP, shreg[7], 1'b0, timing.data_setup);
      end
      BP_WSETUP: enter_ph(BP_WRISE, shreg[7], 1'b1, 8'd1);
      BP_WHIGH:  enter_ph(BP_WLOW, shreg[7], 1'b0, timing.clock_low);
      BP_WLOW: begin
        shreg = shreg << 1;
        bit_idx = bit_idx + 4'd1;
        if (bit_idx < 4'd8) begin
          enter_ph(BP_WSETUP, shreg[7], 1'b0, timing.data_setup);
        end else if (rd_mode && !addr_phase) begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) go_stop();
          else go_read();
        end else begin
          enter_ph(BP_ASETUP, 1'b1, 1'b0, timing.clock_low);
        end
      end
      BP_ASETUP: enter_ph(BP_ARISE, 1'b1, 1'b1, 8'd1);
      BP_AHIGH:  enter_ph(BP_ALOW, 1'b1, 1'b0, timing.clock_low);
      BP_ALOW: begin
        if (nacked) begin
          go_stop();
        end else begin
          addr_phase = 1'b0;
          if (bytes_left == 8'd0) go_stop();
          else if (rd_mode) go_read();
          else enter_ph(BP_NEED, 1'b1, 1'b0, 8'd1);
        end
      end
      BP_RHIGH: begin
        shreg = {shreg[6:0], sda};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          ev_rx = 1'b1;
          ev_byte = shreg;
        end
        enter_ph(BP_RLOW, 1'b1, 1'b0, timing.clock_low);
      end
      BP_RLOW: begin
        if (bit_idx < 4'd8) begin
          enter_ph(BP_RRISE, 1'b1, 1'b1, 8'd1);
        end else begin
          b = (bytes_left == 8'd1);
          shreg = {b, 7'd0};
          bit_idx = 4'd7;
          enter_ph(BP_WSETUP, b, 1'b0, timing.data_setup);
        end
      end
      BP_STPREP: enter_ph(BP_STSETUP, 1'b0, 1'b1, timing.stop_setup);
      BP_STSETUP: begin
        enter_ph(BP_IDLE, 1'b1, 1'b1, 8'd1);
        ph_timer = 8'd0;
        ev_done = 1'b1;
      end
      default: begin
        enter_ph(BP_IDLE, 1'b1, 1'b1, 8'd1);
        ph_timer = 8'd0;
      end
    endcase
  endfunction

  function automatic void bus_tick(logic sda, logic scl);
    case (ph)
      BP_IDLE, BP_NEED: ;
      BP_WRISE: if (scl) enter_ph(BP_WHIGH, sda_lvl, 1'b1, timing.clock_high);
      BP_RRISE: if (scl) enter_ph(BP_RHIGH, sda_lvl, 1'b1, timing.clock_high);
      BP_ARISE: begin
        if (scl) begin
          nacked = sda;
          enter_ph(BP_AHIGH, sda_lvl, 1'b1, timing.clock_high);
        end
      end
      default: begin
        if (ph_timer > 8'd1) ph_timer = ph_timer - 8'd1;
        else phase_expired(sda);
      end
    endcase
  endfunction

  function automatic res_t predict_levels(act_e act, logic [7:0] addr, logic [7:0] cnt,
                                          logic [7:0] data, logic sda, logic scl);
    res_t r;
    ev_rx = 1'b0;
    ev_byte = 8'd0;
    ev_done = 1'b0;
    case (act)
      ACT_TICK: bus_tick(sda, scl);
      ACT_BEGIN: begin
        if (ph == BP_IDLE) begin
          shreg = addr;
          bytes_left = cnt;
          rd_mode = addr[0];
          addr_phase = 1'b1;
          nacked = 1'b0;
          bit_idx = 4'd0;
          enter_ph(BP_FREE, 1'b1, 1'b1, timing.bus_free);
        end
      end
      ACT_SUPPLY: begin
        if (ph == BP_NEED) begin
          shreg = data;
          bytes_left = bytes_left - 8'd1;
          bit_idx = 4'd0;
          enter_ph(BP_WSETUP, shreg[7], 1'b0, timing.data_setup);
        end
      end
      default: ;
    endcase
    r.sda_drive = sda_lvl;
    r.scl_drive = scl_lvl;
    r.rx_byte = ev_rx ? ev_byte : 8'd0;
    r.rx_valid = ev_rx;
    r.need_byte = (ph == BP_NEED);
    r.busy = (ph != BP_IDLE);
    r.done = ev_done;
    r.failed = ev_done & nacked;
    return r;
  endfunction

  task automatic send_item(act_e act, logic [7:0] addr, logic [7:0] cnt, logic [7:0] data,
                           logic sda, logic scl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    addr_byte_i  <= addr;
    byte_count_i <= cnt;
    data_byte_i  <= data;
    sda_in_i     <= sda;
    scl_in_i     <= scl;
    do @(posedge clk_i); while (!in_ready_o);
    levels_q.push_back(predict_levels(act, addr, cnt, data, sda, scl));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_timing(cfg_t c);
    drain();
    write_reg(REG_CLOCK_LOW, c.clock_low);
    write_reg(REG_CLOCK_HIGH, c.clock_high);
    write_reg(REG_DATA_SETUP, c.data_setup);
    write_reg(REG_BUS_FREE, c.bus_free);
    write_reg(REG_START_HOLD, c.start_hold);
    write_reg(REG_STOP_SETUP, c.stop_setup);
    cfg_we_i <= 1'b0;
    timing = c;
  endtask

  function automatic cfg_t uniform_timing(logic [7:0] v);
    cfg_t c;
    c.clock_low = v;
    c.clock_high = v;
    c.data_setup = v;
    c.bus_free = v;
    c.start_hold = v;
    c.stop_setup = v;
    return c;
  endfunction

  function automatic cfg_t random_timing();
    cfg_t c;
    c.clock_low = 8'($urandom_range(0, 4));
    c.clock_high = 8'($urandom_range(0, 4));
    c.data_setup = 8'($urandom_range(0, 4));
    c.bus_free = 8'($urandom_range(0, 4));
    c.start_hold = 8'($urandom_range(0, 4));
    c.stop_setup = 8'($urandom_range(0, 4));
    return c;
  endfunction

  // slave side: ACK/NACK the master, return read bits, stretch SCL
  task automatic slave_tick(logic addr_nack, int unsigned nack_pct, int unsigned stretch_pct);
    logic sda;
    logic scl;
    sda = 1'($urandom_range(1));
    scl = 1'($urandom_range(1));
    if (ph == BP_WRISE || ph == BP_RRISE || ph == BP_ARISE) begin
      scl = ($urandom_range(99) >= stretch_pct);
    end
    if (ph == BP_ARISE) begin
      sda = addr_phase ? addr_nack : ($urandom_range(99) < nack_pct);
    end
    send_item(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom), sda, scl);
  endtask

  task automatic send_noise();
    int unsigned pick;
    pick = $urandom_range(2);
    if (pick == 1 && ph != BP_IDLE) begin
      send_item(ACT_BEGIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom));
    end else if (pick == 2 && ph != BP_NEED) begin
      send_item(ACT_SUPPLY, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom));
    end else begin
      send_item(ACT_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom));
    end
  endtask

  task automatic run_transfer(logic [7:0] addr, logic [7:0] cnt, logic addr_nack,
                              int unsigned nack_pct, int unsigned stretch_pct,
                              int unsigned noise_pct);
    send_item(ACT_BEGIN, addr, cnt, 8'($urandom), 1'($urandom), 1'($urandom));
    bus_items++;
    while (ph != BP_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        send_noise();
      end else begin
        bus_items++;
        if (ph == BP_NEED && $urandom_range(3) != 0) begin
          send_item(ACT_SUPPLY, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    1'($urandom));
        end else begin
          slave_tick(addr_nack, nack_pct, stretch_pct);
        end
      end
    end
  endtask

  task automatic test_idle_items();
    send_item(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_item(ACT_NOP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_SUPPLY, 8'h00, 8'h00, 8'hA5, 1'b1, 1'b0);
    send_item(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_default_write();
    run_transfer(8'hA4, 8'd2, 1'b0, 0, 0, 0);
  endtask

  task automatic test_read();
    program_timing('{clock_low: 8'd1, clock_high: 8'd2, data_setup: 8'd1,
                     bus_free: 8'd2, start_hold: 8'd1, stop_setup: 8'd2});
    run_transfer(8'hA1, 8'd2, 1'b0, 0, 0, 0);
  endtask

  task automatic test_addr_nack();
    run_transfer(8'h5A, 8'hFF, 1'b1, 0, 0, 0);
    run_transfer(8'hFF, 8'hFF, 1'b1, 0, 0, 0);
  endtask

  task automatic test_data_nack();
    run_transfer(8'h3C, 8'd3, 1'b0, 100, 0, 0);
  endtask

  task automatic test_zero_count();
    run_transfer(8'h40, 8'd0, 1'b0, 0, 0, 0);
    run_transfer(8'h41, 8'd0, 1'b0, 0, 0, 0);
  endtask

  task automatic test_clock_stretch();
    run_transfer(8'hC3, 8'd1, 1'b0, 0, 60, 0);
    run_transfer(8'hC2, 8'd1, 1'b0, 0, 60, 0);
  endtask

  task automatic test_ignored_commands();
    run_transfer(8'h92, 8'd1, 1'b0, 0, 0, 30);
  endtask

  task automatic test_zero_timing();
    program_timing(uniform_timing(8'd0));
    run_transfer(8'h00, 8'd1, 1'b0, 0, 0, 0);
  endtask

  task automatic test_max_timing();
    cfg_t c;
    c = uniform_timing(8'd1);
    c.bus_free = 8'd255;
    program_timing(c);
    run_transfer(8'h7F, 8'd0, 1'b0, 0, 0, 0);
  endtask

  task automatic random_slice(int unsigned sender_pct, int unsigned receiver_pct,
                              int unsigned target);
    logic [7:0] addr;
    int unsigned stop_at;
    program_timing(random_timing());
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    stop_at = bus_items + target;
    while (bus_items < stop_at) begin
      addr = 8'($urandom);
      if ($urandom_range(7) == 0) begin
        run_transfer(addr, 8'($urandom), 1'b1, 10, 20, 5);
      end else begin
        run_transfer(addr, 8'($urandom_range(0, 3)), ($urandom_range(9) == 0), 10,
                     ($urandom_range(1) == 0) ? 0 : 30, 5);
      end
      repeat ($urandom_range(0, 2)) begin
        send_item(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom));
      end
      if ($urandom_range(5) == 0) program_timing(random_timing());
    end
  endtask

  task automatic test_random();
    random_slice(38, 61, RANDOM_ITEMS / 3);
    random_slice(61, 38, RANDOM_ITEMS / 3);
    random_slice(0, 0, RANDOM_ITEMS / 3);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t exp_lv;
    got = '{sda_drive: sda_drive_o, scl_drive: scl_drive_o, rx_byte: rx_byte_o,
            rx_valid: rx_valid_o, need_byte: need_byte_o, busy: busy_res_o,
            done: done_res_o, failed: failed_o};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        exp_lv = levels_q.pop_front();
        if (got !== exp_lv) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp sda=%b scl=%b rx=%h/%b need=%b busy=%b done=%b fail=%b",
                     $realtime, exp_lv.sda_drive, exp_lv.scl_drive, exp_lv.rx_byte,
                     exp_lv.rx_valid, exp_lv.need_byte, exp_lv.busy, exp_lv.done,
                     exp_lv.failed);
            $display("             got sda=%b scl=%b rx=%h/%b need=%b busy=%b done=%b fail=%b",
                     got.sda_drive, got.scl_drive, got.rx_byte, got.rx_valid,
                     got.need_byte, got.busy, got.done, got.failed);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    timing = '{clock_low: 8'd5, clock_high: 8'd4, data_setup: 8'd1,
               bus_free: 8'd5, start_hold: 8'd4, stop_setup: 8'd4};
    ph = BP_IDLE;
    ph_timer = 8'd0;
    bit_idx = 4'd0;
    shreg = 8'd0;
    bytes_left = 8'd0;
    rd_mode = 1'b0;
    sda_lvl = 1'b1;
    scl_lvl = 1'b1;
    addr_phase = 1'b0;
    nacked = 1'b0;
    send_idle_pct = 38;
    recv_stall_pct = 61;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_items();
    test_default_write();
    test_read();
    test_addr_nack();
    test_data_nack();
    test_zero_count();
    test_clock_stretch();
    test_ignored_commands();
    test_zero_timing();
    test_max_timing();
    test_random();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && levels_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
